### rtl/vri_pkg.sv
// vri_pkg: word types, register and command codes, and address constants
// of the video register interface. No dependencies.
package vri_pkg;

   typedef struct packed {
      logic [1:0] cmd;
      logic [2:0] reg_offset;
      logic [7:0] wdata;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        nmi_level;
      logic [15:0] cur_vram_addr;
      logic [2:0]  fine_x;
   } rsp_word_type;

   typedef struct packed {
      logic        spr_we;
      logic        spr_re;
      logic [7:0]  spr_addr;
      logic        name_we;
      logic        name_re;
      logic [11:0] name_off;
      logic [7:0]  wdata;
   } mem_req_type;

   typedef struct packed {
      logic        valid;
      logic        rd_spr;
      logic        spr_mask;
      logic [7:0]  rd_direct;
      logic        nmi;
      logic [15:0] cur;
      logic [2:0]  fine;
   } stage_type;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_SET   = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic [2:0] OFS_CONTROL  = 3'd0;
   localparam logic [2:0] OFS_RENDER   = 3'd1;
   localparam logic [2:0] OFS_FLAGS    = 3'd2;
   localparam logic [2:0] OFS_SPR_ADDR = 3'd3;
   localparam logic [2:0] OFS_SPR_DATA = 3'd4;
   localparam logic [2:0] OFS_SCROLL   = 3'd5;
   localparam logic [2:0] OFS_ADDR     = 3'd6;
   localparam logic [2:0] OFS_DATA     = 3'd7;

   localparam logic [2:0] MIR_VERT  = 3'd0;
   localparam logic [2:0] MIR_HORZ  = 3'd1;
   localparam logic [2:0] MIR_LOW   = 3'd2;
   localparam logic [2:0] MIR_HIGH  = 3'd3;
   localparam logic [2:0] MIR_RESET = MIR_HORZ;

   localparam int         SPR_BYTES   = 256;
   localparam int         COLOR_BYTES = 32;
   localparam logic [7:0] SPR_FILL    = 8'hFF;
   localparam logic [7:0] ATTR_MASK   = 8'hE3;

   localparam logic [13:0] PAL_BASE = 14'h3F00;
   localparam logic [13:0] NT_BASE  = 14'h2000;
   localparam logic [15:0] TEMP_KEEP_SCROLL = 16'h8C1F;

   function automatic logic [4:0] pal_index(input logic [4:0] p);
      logic [4:0] r;
      r = p;
      if (p[4] && p[1:0] == 2'b00) begin
         r = {1'b0, p[3:0]};
      end
      return r;
   endfunction

endpackage

### rtl/vri_vram.sv
// vri_vram: nametable and sprite attribute memories with mirroring and the
// post-reset clearing pass. Depends on vri_pkg.
module vri_vram #(
   parameter int NAME_RAM_BYTES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          nt_layout,
   input  vri_pkg::mem_req_type mem_req,
   output logic                busy,
   output logic [7:0]          name_q,
   output logic [7:0]          spr_q
);
   import vri_pkg::*;

   localparam int              NT_AW    = $clog2(NAME_RAM_BYTES);
   localparam logic [12:0]     NT_BYTES = 13'(NAME_RAM_BYTES);
   localparam logic [NT_AW-1:0] NT_LAST = NT_AW'(NAME_RAM_BYTES - 1);

   logic [7:0]       name_mem [NAME_RAM_BYTES];
   logic [7:0]       spr_mem  [SPR_BYTES];
   logic [7:0]       name_q_ff;
   logic [7:0]       spr_q_ff;
   logic             clr_active_ff;
   logic [NT_AW-1:0] clr_cnt_ff;
   logic [11:0]      mirrored;
   logic [12:0]      wrapped;
   logic [NT_AW-1:0] name_idx;

   always_comb begin
      unique case (nt_layout)
         MIR_VERT: mirrored = {1'b0, mem_req.name_off[10:0]};
         MIR_HORZ: mirrored = {1'b0, mem_req.name_off[11], mem_req.name_off[9:0]};
         MIR_LOW:  mirrored = {2'b00, mem_req.name_off[9:0]};
         MIR_HIGH: mirrored = {2'b01, mem_req.name_off[9:0]};
         default:  mirrored = mem_req.name_off;
      endcase
      wrapped = {1'b0, mirrored};
      if (wrapped >= NT_BYTES) begin
         wrapped = wrapped - NT_BYTES;
      end
      name_idx = wrapped[NT_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == NT_LAST) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         name_mem[clr_cnt_ff] <= '0;
      end else if (mem_req.name_we) begin
         name_mem[name_idx] <= mem_req.wdata;
      end
      if (mem_req.name_re) begin
         name_q_ff <= name_mem[name_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         spr_mem[clr_cnt_ff[7:0]] <= SPR_FILL;
      end else if (mem_req.spr_we) begin
         spr_mem[mem_req.spr_addr] <= mem_req.wdata;
      end
      if (mem_req.spr_re) begin
         spr_q_ff <= spr_mem[mem_req.spr_addr];
      end
   end

   assign busy   = clr_active_ff;
   assign name_q = name_q_ff;
   assign spr_q  = spr_q_ff;

endmodule

### rtl/vri_core.sv
// vri_core: register state, address latches, palette RAM, read buffer and
// the registered stage that follows each accepted word. Depends on vri_pkg.
module vri_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  vri_pkg::req_word_type req_word,
   input  logic [7:0]           name_q,
   input  logic                 stage_adv,
   output vri_pkg::mem_req_type  mem_req,
   output vri_pkg::stage_type    stage
);
   import vri_pkg::*;

   logic        nmi_en_ff, nmi_en_in;
   logic        incr32_ff, incr32_in;
   logic [2:0]  status_ff, status_in;
   logic        vbl_ff, vbl_in;
   logic [7:0]  spr_addr_ff, spr_addr_in;
   logic        toggle_ff, toggle_in;
   logic [15:0] temp_ff, temp_in;
   logic [15:0] cur_ff, cur_in;
   logic [2:0]  fine_ff, fine_in;
   logic [7:0]  rbuf_ff, rbuf_in;
   logic        rbuf_pend_ff, rbuf_pend_in;
   logic        rbuf_ram_ff, rbuf_ram_in;
   logic [7:0]  color_ff [COLOR_BYTES];
   stage_type   stage_ff, stage_in;

   logic [7:0]  d;
   logic [13:0] a14;
   logic        is_pal, is_nt;
   logic [7:0]  rb_eff;
   logic [4:0]  color_idx;
   logic        color_we;
   logic        advance;
   logic [7:0]  rd_direct;
   logic        rd_spr, spr_mask;

   assign d         = req_word.wdata;
   assign a14       = cur_ff[13:0];
   assign is_pal    = a14 >= PAL_BASE;
   assign is_nt     = (a14 >= NT_BASE) && !is_pal;
   assign color_idx = pal_index(a14[4:0]);
   // the buffer refill lands in the cycle after its read issues
   assign rb_eff    = rbuf_pend_ff ? (rbuf_ram_ff ? name_q : 8'h00) : rbuf_ff;

   always_comb begin
      nmi_en_in    = nmi_en_ff;
      incr32_in    = incr32_ff;
      status_in    = status_ff;
      vbl_in       = vbl_ff;
      spr_addr_in  = spr_addr_ff;
      toggle_in    = toggle_ff;
      temp_in      = temp_ff;
      cur_in       = cur_ff;
      fine_in      = fine_ff;
      rbuf_in      = rb_eff;
      rbuf_pend_in = 1'b0;
      rbuf_ram_in  = rbuf_ram_ff;
      color_we     = 1'b0;
      advance      = 1'b0;
      rd_direct    = 8'h00;
      rd_spr       = 1'b0;
      spr_mask     = 1'b0;
      mem_req          = '0;
      mem_req.spr_addr = spr_addr_ff;
      mem_req.name_off = a14[11:0];
      mem_req.wdata    = d;
      if (accept) begin
         unique case (req_word.cmd)
            CMD_READ: begin
               unique case (req_word.reg_offset)
                  OFS_FLAGS: begin
                     rd_direct = {status_ff, rb_eff[4:0]};
                     status_in = {1'b0, status_ff[1:0]};
                     vbl_in    = 1'b0;
                     toggle_in = 1'b0;
                  end
                  OFS_SPR_DATA: begin
                     mem_req.spr_re = 1'b1;
                     rd_spr         = 1'b1;
                     spr_mask       = spr_addr_ff[1:0] == 2'd2;
                  end
                  OFS_DATA: begin
                     rbuf_pend_in = 1'b1;
                     rbuf_ram_in  = is_pal || is_nt;
                     mem_req.name_re = is_pal || is_nt;
                     rd_direct = is_pal ? color_ff[color_idx] : rb_eff;
                     advance   = 1'b1;
                  end
                  default: ;
               endcase
            end
            CMD_WRITE: begin
               unique case (req_word.reg_offset)
                  OFS_CONTROL: begin
                     nmi_en_in      = d[7];
                     incr32_in      = d[2];
                     temp_in[11:10] = d[1:0];
                  end
                  OFS_SPR_ADDR: spr_addr_in = d;
                  OFS_SPR_DATA: begin
                     mem_req.spr_we = 1'b1;
                     spr_addr_in    = spr_addr_ff + 8'd1;
                  end
                  OFS_SCROLL: begin
                     if (!toggle_ff) begin
                        fine_in      = d[2:0];
                        temp_in[4:0] = d[7:3];
                        toggle_in    = 1'b1;
                     end else begin
                        temp_in   = (temp_ff & TEMP_KEEP_SCROLL)
                                  | {1'b0, d[2:0], 2'b00, d[7:3], 5'b00000};
                        toggle_in = 1'b0;
                     end
                  end
                  OFS_ADDR: begin
                     if (!toggle_ff) begin
                        temp_in   = {2'b00, d[5:0], temp_ff[7:0]};
                        toggle_in = 1'b1;
                     end else begin
                        temp_in   = {temp_ff[15:8], d};
                        cur_in    = {temp_ff[15:8], d};
                        toggle_in = 1'b0;
                     end
                  end
                  OFS_DATA: begin
                     mem_req.name_we = is_nt;
                     color_we        = is_pal;
                     advance         = 1'b1;
                  end
                  // mask and status writes leave nothing observable
                  default: ;
               endcase
            end
            CMD_SET: begin
               status_in = status_ff | d[7:5];
               if (d[7]) begin
                  vbl_in = 1'b1;
               end
            end
            CMD_CLEAR: begin
               status_in = status_ff & ~d[7:5];
               if (d[7]) begin
                  vbl_in = 1'b0;
               end
            end
         endcase
      end
      if (advance) begin
         cur_in = cur_ff + (incr32_ff ? 16'd32 : 16'd1);
      end

      stage_in = stage_ff;
      if (accept) begin
         stage_in.valid     = 1'b1;
         stage_in.rd_spr    = rd_spr;
         stage_in.spr_mask  = spr_mask;
         stage_in.rd_direct = rd_direct;
         stage_in.nmi       = nmi_en_in & vbl_in;
         stage_in.cur       = cur_in;
         stage_in.fine      = fine_in;
      end else if (stage_adv) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nmi_en_ff    <= 1'b0;
         incr32_ff    <= 1'b0;
         status_ff    <= '0;
         vbl_ff       <= 1'b0;
         spr_addr_ff  <= '0;
         toggle_ff    <= 1'b0;
         temp_ff      <= '0;
         cur_ff       <= '0;
         fine_ff      <= '0;
         rbuf_ff      <= '0;
         rbuf_pend_ff <= 1'b0;
         rbuf_ram_ff  <= 1'b0;
         stage_ff     <= '0;
      end else begin
         nmi_en_ff    <= nmi_en_in;
         incr32_ff    <= incr32_in;
         status_ff    <= status_in;
         vbl_ff       <= vbl_in;
         spr_addr_ff  <= spr_addr_in;
         toggle_ff    <= toggle_in;
         temp_ff      <= temp_in;
         cur_ff       <= cur_in;
         fine_ff      <= fine_in;
         rbuf_ff      <= rbuf_in;
         rbuf_pend_ff <= rbuf_pend_in;
         rbuf_ram_ff  <= rbuf_ram_in;
         stage_ff     <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLOR_BYTES; i++) begin
            color_ff[i] <= '0;
         end
      end else if (color_we) begin
         color_ff[color_idx] <= d;
      end
   end

   assign stage = stage_ff;

endmodule

### rtl/video_register_interface_unit.sv
// video_register_interface_unit: top level with the config port and the
// result register. Depends on vri_pkg, vri_core and vri_vram.
//
// CPU-side register file of a tile video processor. One request word is
// taken per clock while req_stall is low. Its result word passes through the
// first register stage, which holds the state update and the memory read,
// and then the second, the result register. Sustained rate is one word per
// cycle when neither the clearing pass nor a stalled result holds the flow,
// since each word makes at most one access to each single-port nametable
// and sprite memory. After reset the block clears the nametable RAM and
// fills sprite memory with 0xFF; req_stall stays high during that pass,
// while config writes are taken as usual. The nametable layout register is
// at config addresses 0 to 3, which alias one another.
module video_register_interface_unit #(
   parameter int NAME_RAM_BYTES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  vri_pkg::req_word_type  req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output vri_pkg::rsp_word_type  rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import vri_pkg::*;

   logic         layout_wr;
   logic [2:0]   nt_layout_ff;
   logic         accept;
   logic         busy;
   logic         stage_adv;
   logic [7:0]   name_q, spr_q;
   mem_req_type  mem_req;
   stage_type    stage;
   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   assign layout_wr = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         nt_layout_ff <= MIR_RESET;
      end else if (layout_wr) begin
         nt_layout_ff <= csr_pwdata[2:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {29'd0, nt_layout_ff};

   assign stage_adv = stage.valid && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = busy || (stage.valid && !stage_adv);
   assign accept    = req_valid && !req_stall;

   vri_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_word  (req_word),
      .name_q    (name_q),
      .stage_adv (stage_adv),
      .mem_req   (mem_req),
      .stage     (stage)
   );

   vri_vram #(
      .NAME_RAM_BYTES (NAME_RAM_BYTES)
   ) u_vram (
      .clock       (clock),
      .reset       (reset),
      .nt_layout   (nt_layout_ff),
      .mem_req     (mem_req),
      .busy        (busy),
      .name_q      (name_q),
      .spr_q       (spr_q)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (stage_adv) begin
         rsp_valid_in        = 1'b1;
         rsp_in.rdata        = stage.rd_spr
                             ? (spr_q & (stage.spr_mask ? ATTR_MASK : 8'hFF))
                             : stage.rd_direct;
         rsp_in.nmi_level     = stage.nmi;
         rsp_in.cur_vram_addr = stage.cur;
         rsp_in.fine_x        = stage.fine;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall)
      else $error("word accepted during clearing pass");

   a_stage_blocked: assert property (@(posedge clock) disable iff (reset)
      stage.valid && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("word accepted while stage is blocked");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> stage.valid)
      else $error("accepted word missing from stage");

   a_stage_to_rsp: assert property (@(posedge clock) disable iff (reset)
      stage_adv |=> rsp_valid_ff)
      else $error("stage advanced without result");
`endif

endmodule
